/* rtl/core/mcd_pkg.sv */
// shared types and constants for the millisecond to calendar date converter
// stage boundary structs, reciprocal constants for the divisions, month table
// no dependencies
package mcd_pkg;

  // configuration register index
  localparam logic [1:0] REG_EPOCH = 2'd0;

  // calendar constants
  localparam int unsigned BASE_YEAR     = 2016;
  localparam int unsigned MS_PER_SEC    = 1000;
  localparam int unsigned ROUND_HALF    = 500;
  localparam int unsigned SEC_PER_DAY   = 86400;
  localparam int unsigned SEC_PER_HOUR  = 3600;
  localparam int unsigned SEC_PER_MIN   = 60;
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned DAYS_LEAP     = 366;
  localparam int unsigned DAYS_PER_CYC  = 1461;
  localparam int unsigned DAYS_PER_WEEK = 7;

  // floor reciprocals, estimate may be one low and gets a correction step
  // (ms >> 3) / 125 and (now >> 7) / 675, both scaled by 2^32
  localparam logic [25:0] MS_RECIP  = 26'((64'd1 << 32) / 125);
  localparam logic [22:0] DAY_RECIP = 23'((64'd1 << 32) / 675);

  // ceiling reciprocals, exact over the value ranges used here
  localparam int unsigned HOUR_SHIFT = 29;
  localparam int unsigned CYC_SHIFT  = 27;
  localparam int unsigned WEEK_SHIFT = 19;
  localparam int unsigned MIN_SHIFT  = 18;
  localparam logic [17:0] HOUR_RECIP = 18'(((64'd1 << 29) + 64'd3599) / 3600);
  localparam logic [16:0] CYC_RECIP  = 17'(((64'd1 << 27) + 64'd1460) / 1461);
  localparam logic [16:0] WEEK_RECIP = 17'(((64'd1 << 19) + 64'd6) / 7);
  localparam logic [12:0] MIN_RECIP  = 13'(((64'd1 << 18) + 64'd59) / 60);

  // first day of each month within a common year, zero based
  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // seconds since the base date plus the raw millisecond remainder
  typedef struct packed {
    logic [31:0] now;
    logic [9:0]  ms_rem;
  } mcd_time_t;

  // day count split into four-year cycle, day in cycle, weekday, time of day
  typedef struct packed {
    logic [5:0]  cycle;
    logic [10:0] rem_days;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [11:0] rem_tod;
    logic [9:0]  ms_rem;
  } mcd_split_t;

  // finished result
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
  } mcd_date_t;

endpackage

/* rtl/core/millis_to_calendar_date.sv */
// Millisecond uptime to calendar date and time converter, top level.
// Depends on mcd_pkg, mcd_secs, mcd_days and mcd_date.
//
// Usage:
// - s_tvalid/s_tready/s_tdata carry one uptime count in milliseconds per
//   transaction. m_tvalid/m_tready/m_tdata carry one calendar result per
//   input transaction, in the same order.
// - The APB port holds one register, epoch_seconds at address 0: seconds
//   from 2016-01-01 00:00 to uptime zero. Write it only while no
//   transaction is in flight. pready is tied high; reads return the value.
// - Results pass through nine register stages: three for the millisecond
//   split, rounding and epoch add, four for the day count, time of day,
//   cycle and weekday, two for the year, month, day, minute and second.
// - Throughput is one transaction per cycle unless the receiver stalls. Every
//   stage has its own valid bit and a ready chain, so a stalled receiver holds
//   the output stage while bubbles further up keep filling; s_tready falls only
//   once all stages hold data. Nothing is dropped or repeated.
// - Synchronous reset empties the pipeline and clears epoch_seconds to 0.
module millis_to_calendar_date (
  input  logic        clk,
  input  logic        rst,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [31:0] uptime_ms
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata   // [11:0] year, [15:12] month, [20:16] day_of_month,
                                // [23:21] weekday, [28:24] hour, [34:29] minute,
                                // [40:35] second, [50:41] millisecond, [55:51] zero
);

  logic [31:0] epoch_seconds;
  logic        cfg_wr;

  logic                time_valid, time_ready;
  mcd_pkg::mcd_time_t  time_data;
  logic                split_valid, split_ready;
  mcd_pkg::mcd_split_t split_data;
  mcd_pkg::mcd_date_t  date_data;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch_seconds <= 32'd0;
    end else if (cfg_wr && paddr == mcd_pkg::REG_EPOCH) begin
      epoch_seconds <= pwdata;
    end
  end

  assign prdata = (paddr == mcd_pkg::REG_EPOCH) ? epoch_seconds : 32'd0;

  // pipeline sections
  mcd_secs u_secs (
    .clk           (clk),
    .rst           (rst),
    .epoch_seconds (epoch_seconds),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_ms         (s_tdata),
    .out_valid     (time_valid),
    .out_ready     (time_ready),
    .out_data      (time_data)
  );

  mcd_days u_days (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (time_valid),
    .in_ready  (time_ready),
    .in_data   (time_data),
    .out_valid (split_valid),
    .out_ready (split_ready),
    .out_data  (split_data)
  );

  mcd_date u_date (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (split_valid),
    .in_ready  (split_ready),
    .in_data   (split_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (date_data)
  );

  // output packing, first field lowest
  assign m_tdata = {5'd0, date_data.millisecond, date_data.second, date_data.minute,
                    date_data.hour, date_data.weekday, date_data.day_of_month,
                    date_data.month, date_data.year};

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // input only backs up when the output stage is full and stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while output could move");

  // epoch write lands in the register
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && paddr == mcd_pkg::REG_EPOCH) |=> (epoch_seconds == $past(pwdata)))
    else $error("epoch write lost");

  // corrected divisions keep every field in range
  a_fields_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (date_data.month >= 4'd1 && date_data.month <= 4'd12 &&
                  date_data.day_of_month >= 5'd1 && date_data.weekday <= 3'd6 &&
                  date_data.hour <= 5'd23 && date_data.minute <= 6'd59 &&
                  date_data.second <= 6'd59 && date_data.millisecond <= 10'd999))
    else $error("result field out of range");

endmodule

/* rtl/core/mcd_secs.sv */
// three stages: split uptime into seconds and milliseconds, round, add epoch
// depends on mcd_pkg
module mcd_secs (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         epoch_seconds,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         in_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output mcd_pkg::mcd_time_t  out_data
);

  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  logic [22:0] s1_q;
  logic [31:0] s1_ms;
  logic [22:0] s2_q;
  logic [9:0]  s2_rem;
  mcd_pkg::mcd_time_t s3;

  logic [54:0] prod1;
  logic [32:0] prod2;
  logic [10:0] rem_est;
  logic [22:0] q_fix;
  logic [9:0]  rem_fix;
  logic [22:0] secs;

  // stage advance chain
  assign adv3     = !v3 || out_ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // stage 1: quotient estimate of ms / 1000
  assign prod1 = 55'(in_ms[31:3]) * 55'(mcd_pkg::MS_RECIP);

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_q  <= prod1[54:32];
      s1_ms <= in_ms;
    end
  end

  // stage 2: remainder and one-step correction
  always_comb begin
    prod2   = 33'(s1_q) * 33'(mcd_pkg::MS_PER_SEC);
    rem_est = s1_ms[10:0] - prod2[10:0];
    if (rem_est >= 11'(mcd_pkg::MS_PER_SEC)) begin
      q_fix   = s1_q + 23'd1;
      rem_fix = 10'(rem_est - 11'(mcd_pkg::MS_PER_SEC));
    end else begin
      q_fix   = s1_q;
      rem_fix = rem_est[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_q   <= q_fix;
      s2_rem <= rem_fix;
    end
  end

  // stage 3: round half up and add the epoch offset, wrapping
  assign secs = s2_q + 23'(s2_rem >= 10'(mcd_pkg::ROUND_HALF));

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3.now    <= epoch_seconds + 32'(secs);
      s3.ms_rem <= s2_rem;
    end
  end

  assign out_valid = v3;
  assign out_data  = s3;

endmodule

/* rtl/core/mcd_days.sv */
// four stages: seconds into day count and time of day, then cycle and weekday
// depends on mcd_pkg
module mcd_days (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mcd_pkg::mcd_time_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mcd_pkg::mcd_split_t out_data
);

  logic v4, v5, v6, v7;
  logic adv4, adv5, adv6, adv7;

  logic [31:0] s4_now;
  logic [15:0] s4_d;
  logic [9:0]  s4_ms;
  logic [15:0] s5_days;
  logic [16:0] s5_tod;
  logic [9:0]  s5_ms;
  logic [15:0] s6_days;
  logic [16:0] s6_tod;
  logic [4:0]  s6_hour;
  logic [5:0]  s6_cycle;
  logic [12:0] s6_q7;
  logic [9:0]  s6_ms;
  mcd_pkg::mcd_split_t s7;

  logic [47:0] prod4;
  logic [32:0] prod5;
  logic [17:0] tod_est;
  logic [15:0] days_fix;
  logic [16:0] tod_fix;
  logic [34:0] hour_p;
  logic [32:0] cyc_p;
  logic [32:0] wk_p;
  logic [16:0] hour_sec;
  logic [16:0] cyc_day;
  logic [15:0] wk_day;

  // stage advance chain
  assign adv7     = !v7 || out_ready;
  assign adv6     = !v6 || adv7;
  assign adv5     = !v5 || adv6;
  assign adv4     = !v4 || adv5;
  assign in_ready = adv4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (adv4) v4 <= in_valid;
      if (adv5) v5 <= v4;
      if (adv6) v6 <= v5;
      if (adv7) v7 <= v6;
    end
  end

  // stage 4: day count estimate of now / 86400
  assign prod4 = 48'(in_data.now[31:7]) * 48'(mcd_pkg::DAY_RECIP);

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_now <= in_data.now;
      s4_d   <= prod4[47:32];
      s4_ms  <= in_data.ms_rem;
    end
  end

  // stage 5: time of day and one-step correction
  always_comb begin
    prod5   = 33'(s4_d) * 33'(mcd_pkg::SEC_PER_DAY);
    tod_est = s4_now[17:0] - prod5[17:0];
    if (tod_est >= 18'(mcd_pkg::SEC_PER_DAY)) begin
      days_fix = s4_d + 16'd1;
      tod_fix  = 17'(tod_est - 18'(mcd_pkg::SEC_PER_DAY));
    end else begin
      days_fix = s4_d;
      tod_fix  = tod_est[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      s5_days <= days_fix;
      s5_tod  <= tod_fix;
      s5_ms   <= s4_ms;
    end
  end

  // stage 6: hour, four-year cycle and week count by exact reciprocals
  assign hour_p = 35'(s5_tod) * 35'(mcd_pkg::HOUR_RECIP);
  assign cyc_p  = 33'(s5_days) * 33'(mcd_pkg::CYC_RECIP);
  assign wk_p   = 33'(s5_days) * 33'(mcd_pkg::WEEK_RECIP);

  always_ff @(posedge clk) begin
    if (adv6) begin
      s6_days  <= s5_days;
      s6_tod   <= s5_tod;
      s6_hour  <= hour_p[mcd_pkg::HOUR_SHIFT +: 5];
      s6_cycle <= cyc_p[mcd_pkg::CYC_SHIFT +: 6];
      s6_q7    <= wk_p[mcd_pkg::WEEK_SHIFT +: 13];
      s6_ms    <= s5_ms;
    end
  end

  // stage 7: remainders of the three divisions
  assign hour_sec = 17'(s6_hour) * 17'(mcd_pkg::SEC_PER_HOUR);
  assign cyc_day  = 17'(s6_cycle) * 17'(mcd_pkg::DAYS_PER_CYC);
  assign wk_day   = 16'(s6_q7) * 16'(mcd_pkg::DAYS_PER_WEEK);

  always_ff @(posedge clk) begin
    if (adv7) begin
      s7.cycle    <= s6_cycle;
      s7.rem_days <= s6_days[10:0] - cyc_day[10:0];
      s7.weekday  <= s6_days[2:0] - wk_day[2:0];
      s7.hour     <= s6_hour;
      s7.rem_tod  <= s6_tod[11:0] - hour_sec[11:0];
      s7.ms_rem   <= s6_ms;
    end
  end

  assign out_valid = v7;
  assign out_data  = s7;

endmodule

/* rtl/core/mcd_date.sv */
// two stages: year and day of year, minute, then month, day and second
// depends on mcd_pkg; the last stage is the block's output register
module mcd_date (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mcd_pkg::mcd_split_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mcd_pkg::mcd_date_t  out_data
);

  logic v8, v9;
  logic adv8, adv9;

  logic [5:0]  s8_minute;
  logic [11:0] s8_rem_tod;
  logic [4:0]  s8_hour;
  logic [1:0]  s8_yoff;
  logic [8:0]  s8_doy;
  logic        s8_leap;
  logic [5:0]  s8_cycle;
  logic [2:0]  s8_weekday;
  logic [9:0]  s8_ms;
  mcd_pkg::mcd_date_t s9;

  logic [24:0] min_p;
  logic [10:0] t_days;
  logic [10:0] doy_wide;
  logic [1:0]  yoff;
  logic [8:0]  doy;
  logic        leap;
  logic [11:0] min_sec;
  logic [3:0]  mon_idx;
  logic [8:0]  mon_start;
  logic [8:0]  start_m;

  // stage advance chain
  assign adv9     = !v9 || out_ready;
  assign adv8     = !v8 || adv9;
  assign in_ready = adv8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else begin
      if (adv8) v8 <= in_valid;
      if (adv9) v9 <= v8;
    end
  end

  // stage 8: minute, and year within the cycle with the leap year first
  assign min_p  = 25'(in_data.rem_tod) * 25'(mcd_pkg::MIN_RECIP);
  assign t_days = in_data.rem_days - 11'(mcd_pkg::DAYS_LEAP);

  always_comb begin
    doy_wide = t_days;
    if (in_data.rem_days < 11'(mcd_pkg::DAYS_LEAP)) begin
      yoff     = 2'd0;
      doy_wide = in_data.rem_days;
      leap     = 1'b1;
    end else if (t_days < 11'(mcd_pkg::DAYS_PER_YEAR)) begin
      yoff = 2'd1;
      leap = 1'b0;
    end else if (t_days < 11'(2 * mcd_pkg::DAYS_PER_YEAR)) begin
      yoff     = 2'd2;
      doy_wide = t_days - 11'(mcd_pkg::DAYS_PER_YEAR);
      leap     = 1'b0;
    end else begin
      yoff     = 2'd3;
      doy_wide = t_days - 11'(2 * mcd_pkg::DAYS_PER_YEAR);
      leap     = 1'b0;
    end
    doy = doy_wide[8:0];
  end

  always_ff @(posedge clk) begin
    if (adv8) begin
      s8_minute  <= min_p[mcd_pkg::MIN_SHIFT +: 6];
      s8_rem_tod <= in_data.rem_tod;
      s8_hour    <= in_data.hour;
      s8_yoff    <= yoff;
      s8_doy     <= doy;
      s8_leap    <= leap;
      s8_cycle   <= in_data.cycle;
      s8_weekday <= in_data.weekday;
      s8_ms      <= in_data.ms_rem;
    end
  end

  // stage 9: month by parallel compares against the month start table
  always_comb begin
    mon_idx   = 4'd0;
    mon_start = 9'd0;
    for (int m = 1; m < 12; m++) begin
      start_m = mcd_pkg::MONTH_START[m] + 9'(s8_leap && (m >= 2));
      if (s8_doy >= start_m) begin
        mon_idx   = 4'(m);
        mon_start = start_m;
      end
    end
  end

  assign min_sec = 12'(s8_minute) * 12'(mcd_pkg::SEC_PER_MIN);

  always_ff @(posedge clk) begin
    if (adv9) begin
      s9.year         <= 12'(mcd_pkg::BASE_YEAR) + {4'd0, s8_cycle, 2'b00} + 12'(s8_yoff);
      s9.month        <= mon_idx + 4'd1;
      s9.day_of_month <= 5'(s8_doy - mon_start) + 5'd1;
      s9.weekday      <= s8_weekday;
      s9.hour         <= s8_hour;
      s9.minute       <= s8_minute;
      s9.second       <= s8_rem_tod[5:0] - min_sec[5:0];
      s9.millisecond  <= s8_ms;
    end
  end

  assign out_valid = v9;
  assign out_data  = s9;

endmodule

/* sim/millis_to_calendar_date_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for millis_to_calendar_date: uptime stream in, date stream out
// holds its own calendar predictor and scoreboard class; depends on mcd_pkg and the dut
module millis_to_calendar_date_tb;

  localparam logic [1:0]  EPOCH_ADDR  = 2'(4 * mcd_pkg::REG_EPOCH);
  localparam int unsigned STUCK_LIMIT = 3000;
  localparam int unsigned RAND_ITEMS  = 55;
  localparam int unsigned NUM_PHASES  = 10;

  // one decoded calendar result
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
    logic [4:0]  pad;
  } cal_date_t;

  // calendar predictor and store of dates still owed by the dut
  class calendar_scoreboard;
    logic [31:0] epoch;
    cal_date_t   pending_dates[$];
    int unsigned errors;

    function new();
      epoch = '0;
      errors = 0;
    endfunction

    function automatic cal_date_t to_calendar(logic [31:0] ms);
      logic [32:0] rounded;
      logic [31:0] secs, now, days, tod, cyc, in_cyc, yoff, doy, mlen;
      bit          leap;
      int          mon;
      cal_date_t   d;
      // round to whole seconds with a carry bit, then add the epoch modulo 2^32
      rounded = {1'b0, ms} + 33'(mcd_pkg::ROUND_HALF);
      secs = 32'(rounded / mcd_pkg::MS_PER_SEC);
      now = epoch + secs;
      days = now / mcd_pkg::SEC_PER_DAY;
      tod = now % mcd_pkg::SEC_PER_DAY;
      cyc = days / mcd_pkg::DAYS_PER_CYC;
      in_cyc = days % mcd_pkg::DAYS_PER_CYC;
      // leap year leads each four-year cycle
      if (in_cyc < mcd_pkg::DAYS_LEAP) begin
        yoff = 0;
        doy = in_cyc;
        leap = 1'b1;
      end else begin
        yoff = 1 + (in_cyc - mcd_pkg::DAYS_LEAP) / mcd_pkg::DAYS_PER_YEAR;
        doy = (in_cyc - mcd_pkg::DAYS_LEAP) % mcd_pkg::DAYS_PER_YEAR;
        leap = 1'b0;
      end
      // walk the months
      for (mon = 0; mon < 11; mon++) begin
        case (mon)
          1: begin
            mlen = leap ? 29 : 28;
          end
          3, 5, 8, 10: begin
            mlen = 30;
          end
          default: begin
            mlen = 31;
          end
        endcase
        if (doy < mlen) break;
        doy -= mlen;
      end
      d.year = 12'(mcd_pkg::BASE_YEAR + 4 * cyc + yoff);
      d.month = 4'(mon + 1);
      d.mday = 5'(doy + 1);
      d.weekday = 3'(days % mcd_pkg::DAYS_PER_WEEK);
      d.hour = 5'(tod / mcd_pkg::SEC_PER_HOUR);
      d.minute = 6'((tod % mcd_pkg::SEC_PER_HOUR) / mcd_pkg::SEC_PER_MIN);
      d.second = 6'(tod % mcd_pkg::SEC_PER_MIN);
      d.millisecond = 10'(ms % mcd_pkg::MS_PER_SEC);
      d.pad = '0;
      return d;
    endfunction

    function void note_uptime(logic [31:0] ms);
      pending_dates.push_back(to_calendar(ms));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_date(logic [55:0] bus);
      cal_date_t want;
      if (pending_dates.size() == 0) begin
        $error("date transaction with nothing pending: %h", bus);
        errors++;
        return;
      end
      want = pending_dates.pop_front();
      compare_field("year", want.year, bus[11:0]);
      compare_field("month", want.month, bus[15:12]);
      compare_field("day_of_month", want.mday, bus[20:16]);
      compare_field("weekday", want.weekday, bus[23:21]);
      compare_field("hour", want.hour, bus[28:24]);
      compare_field("minute", want.minute, bus[34:29]);
      compare_field("second", want.second, bus[40:35]);
      compare_field("millisecond", want.millisecond, bus[50:41]);
      compare_field("pad", want.pad, bus[55:51]);
    endfunction

    function int pending();
      return pending_dates.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] uptime_ms
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;   // [11:0] year, [15:12] month, [20:16] day_of_month,
                          // [23:21] weekday, [28:24] hour, [34:29] minute,
                          // [40:35] second, [50:41] millisecond, [55:51] zero

  calendar_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned stuck_cycles = 0;

  millis_to_calendar_date dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #10 clk = ~clk;

  // observe both streams, then pick the next receiver stall
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_uptime(s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_date(m_tdata);
    m_tready <= ($urandom_range(99) < recv_stall_pct) ? 1'b0 : 1'b1;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // offer one uptime value, with random idle cycles ahead of it
  task automatic push_uptime(input logic [31:0] ms);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata <= $urandom;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ms;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop sending and wait for every owed date
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // apb write of the epoch register, setup then access
  task automatic write_epoch(input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= EPOCH_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.epoch = value;
  endtask

  // random uptime, weighted toward low values, rounding edges and the top of the range
  function automatic logic [31:0] random_uptime();
    logic [31:0] ms;
    case ($urandom_range(3))
      0: begin
        ms = $urandom;
      end
      1: begin
        ms = 1000 * $urandom_range(100000) + $urandom_range(999);
      end
      2: begin
        ms = 1000 * $urandom_range(4294966) + ($urandom_range(1) ? 499 : 500);
      end
      default: begin
        ms = 32'hFFFF_FFFF - $urandom_range(2000);
      end
    endcase
    return ms;
  endfunction

  // epochs per phase: reset value, top of range, leap day, year ends, cycle end
  logic [31:0] phase_epoch [NUM_PHASES] = '{
    32'd0, 32'hFFFF_FFFF, 32'd5097599, 32'd31622399, 32'd126230399,
    32'd0, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0
  };
  logic [31:0] seam_uptimes [6] = '{
    32'd0, 32'd499, 32'd500, 32'd1000, 32'd86400000, 32'hFFFF_FFFF
  };
  logic [31:0] edge_uptimes [14] = '{
    32'd1, 32'd999, 32'd1499, 32'd1500, 32'd59499, 32'd59500, 32'd3599500,
    32'd86399499, 32'd86399500, 32'hFFFF_FE0B, 32'hFFFF_FE0C, 32'h8000_0000,
    32'hAAAA_AAAA, 32'h5555_5555
  };

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // no idling, sender idle, receiver stall, both
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 68;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 68;
        end
        default: begin
          send_idle_pct = 19;
          recv_stall_pct = 19;
        end
      endcase
      // the first phase runs on the reset value, later ones rewrite it
      if (p > 0) begin
        drain();
        write_epoch(p >= 7 ? $urandom : phase_epoch[p]);
      end
      foreach (seam_uptimes[i]) push_uptime(seam_uptimes[i]);
      if (p == 0) begin
        foreach (edge_uptimes[i]) push_uptime(edge_uptimes[i]);
      end
      for (int n = 0; n < RAND_ITEMS; n++) push_uptime(random_uptime());
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/mcd_pkg.sv
rtl/core/mcd_secs.sv
rtl/core/mcd_days.sv
rtl/core/mcd_date.sv
rtl/core/millis_to_calendar_date.sv
sim/millis_to_calendar_date_tb.sv
